// ===== rtl/mini_mips_execute_unit_defines.svh =====
// Assertion macros for the execute unit.
// Used by the top level only; no other dependencies.
`ifndef MINI_MIPS_EXECUTE_UNIT_DEFINES_SVH
`define MINI_MIPS_EXECUTE_UNIT_DEFINES_SVH
// Assertion that an implication holds on every clock edge outside reset.
`define MME_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that holds on every clock edge, reset included.
`define MME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/mme_pkg.sv =====
// Package for the execute unit: opcodes, status codes and request types.
// No dependencies.
package mme_pkg;
    localparam logic [1:0] OP_EXEC = 2'd0;
    localparam logic [1:0] OP_MWR  = 2'd1;
    localparam logic [1:0] OP_MRD  = 2'd2;
    localparam logic [1:0] OP_RRD  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_FAULT   = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_CODE_BASE = 1'b0;
    localparam logic CFG_DATA_BASE = 1'b1;

    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_LA    = 6'h2F;
    localparam logic [5:0] OPC_LB    = 6'h20;
    localparam logic [5:0] OPC_LW    = 6'h23;
    localparam logic [5:0] OPC_SW    = 6'h2B;
    localparam logic [5:0] OPC_ADDI  = 6'h08;
    localparam logic [5:0] OPC_BGE   = 6'h07;
    localparam logic [5:0] OPC_J     = 6'h02;
    localparam logic [5:0] FUNCT_ADD = 6'h20;

    // Request and result payloads as they travel on the two channels.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] instruction;
        logic [9:0]  access_index;
        logic [31:0] write_value;
    } t_exec_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] next_pc;
        logic [31:0] read_data;
    } t_exec_rsp;

    // Classified kind of work for the back part.
    typedef enum logic [3:0] {
        K_ADD, K_LA, K_LB, K_LW, K_SW, K_ADDI, K_BGE, K_J,
        K_HALT, K_ILL, K_MWR, K_MRD, K_RRD
    } t_kind;

    // Classified request as it travels through the queue.
    typedef struct packed {
        t_kind       kind;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [25:0] imm26;
        logic [9:0]  idx;
        logic [31:0] wval;
    } t_req;
endpackage

// ===== rtl/mme_stream_if.sv =====
// Valid/ready channel carrying a payload of a given type.
// No dependencies.
interface mme_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mme_front.sv =====
// Front part: decodes an incoming request into a classified entry.
// Depends on mme_pkg.
module mme_front import mme_pkg::*; (
    input  logic [1:0]  i_op,
    input  logic [31:0] i_instruction,
    input  logic [9:0]  i_access_index,
    input  logic [31:0] i_write_value,
    output t_req        o_req
);
    logic [5:0] opc;
    logic [5:0] funct;
    assign opc   = i_instruction[31:26];
    assign funct = i_instruction[5:0];

    // Pick the kind of work from the op and the instruction fields.
    always_comb begin
        o_req.rs    = i_instruction[25:21];
        o_req.rt    = i_instruction[20:16];
        o_req.rd    = i_instruction[15:11];
        o_req.imm26 = i_instruction[25:0];
        o_req.idx   = i_access_index;
        o_req.wval  = i_write_value;
        o_req.kind  = K_ILL;
        unique case (i_op)
            OP_MWR: o_req.kind = K_MWR;
            OP_MRD: o_req.kind = K_MRD;
            OP_RRD: o_req.kind = K_RRD;
            default: begin
                if (i_instruction == 32'd0) begin
                    o_req.kind = K_HALT;
                end else begin
                    unique case (opc)
                        OPC_RTYPE: o_req.kind = (funct == FUNCT_ADD) ? K_ADD : K_ILL;
                        OPC_LA:    o_req.kind = K_LA;
                        OPC_LB:    o_req.kind = K_LB;
                        OPC_LW:    o_req.kind = K_LW;
                        OPC_SW:    o_req.kind = K_SW;
                        OPC_ADDI:  o_req.kind = K_ADDI;
                        OPC_BGE:   o_req.kind = K_BGE;
                        OPC_J:     o_req.kind = K_J;
                        default:   o_req.kind = K_ILL;
                    endcase
                end
            end
        endcase
    end
endmodule

// ===== rtl/mme_queue.sv =====
// Two-entry queue between the front and back parts.
// Depends on mme_pkg.
module mme_queue import mme_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_req o_data
);
    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== rtl/mme_back.sv =====
// Back part: register file, data memory and result register.
// Depends on mme_pkg.
module mme_back import mme_pkg::*; #(
    parameter int DMEM_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  t_req        i_req,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_next_pc,
    output logic [31:0] o_read_data
);
    localparam int AW = $clog2(DMEM_WORDS);
    localparam logic [32:0] DMEM_BYTES = 33'(DMEM_WORDS) * 33'd4;

    logic [31:0] r_pc, r_data_base;
    logic [31:0] r_regs [32];
    logic [31:0] r_dmem [DMEM_WORDS];
    logic        r_stopped;
    logic [1:0]  r_stop_code;

    // Stage 2 holds a request that needs a memory read.
    logic        r_s2_valid, r_s2_lb, r_s2_mrd;
    logic [1:0]  r_s2_byte;
    logic [4:0]  r_s2_rt;
    logic [31:0] r_s2_mem;

    logic        r_ov;
    logic [1:0]  r_st;
    logic [31:0] r_pcout, r_rdata;

    logic        out_free, s2_go, take, s2_free, is_load, ld_ok;
    logic [31:0] rs_v, rt_v, ea, off, sx, n_pc, n_val, lbv;
    logic [1:0]  n_st;
    logic        n_wr, n_mwr;
    logic [4:0]  n_dst;
    logic [AW-1:0] maddr;

    // Register reads; register 0 always reads as zero.
    always_comb begin
        rs_v = (i_req.rs == 5'd0) ? 32'd0 : r_regs[i_req.rs];
        rt_v = (i_req.rt == 5'd0) ? 32'd0 : r_regs[i_req.rt];
    end

    assign out_free = !r_ov || i_ready;
    assign s2_go    = r_s2_valid && out_free;
    assign s2_free  = !r_s2_valid || s2_go;
    // A request waits while any load sits in stage 2 to write its register.
    assign take     = i_valid && s2_free && !r_s2_valid && out_free;
    assign o_pop    = take;

    assign sx  = {{16{i_req.imm26[15]}}, i_req.imm26[15:0]};
    assign ea  = rs_v + sx;
    assign off = ea - r_data_base;
    assign maddr = (i_req.kind == K_MWR || i_req.kind == K_MRD)
                   ? AW'(i_req.idx) : off[AW+1:2];

    // Execute one request.
    always_comb begin
        n_st   = ST_OK;
        n_pc   = r_pc + 32'd4;
        n_val  = 32'd0;
        n_wr   = 1'b0;
        n_mwr  = 1'b0;
        n_dst  = i_req.rt;
        is_load = 1'b0;
        ld_ok  = {1'b0, off} < DMEM_BYTES;
        unique case (i_req.kind)
            K_ADD: begin
                n_dst = i_req.rd; n_val = rs_v + rt_v; n_wr = 1'b1;
            end
            K_LA: begin
                n_val = r_data_base + {16'd0, i_req.imm26[15:0]}; n_wr = 1'b1;
            end
            K_ADDI: begin
                n_val = ea; n_wr = 1'b1;
            end
            K_LB: begin
                if (ld_ok) is_load = 1'b1; else n_st = ST_FAULT;
            end
            K_LW: begin
                if (ld_ok && ea[1:0] == 2'd0) is_load = 1'b1; else n_st = ST_FAULT;
            end
            K_SW: begin
                if (ld_ok && ea[1:0] == 2'd0) n_mwr = 1'b1; else n_st = ST_FAULT;
            end
            K_BGE: begin
                if ($signed(rs_v) >= $signed(rt_v))
                    n_pc = {14'd0, i_req.imm26[15:0], 2'b00};
            end
            K_J:    n_pc = {4'd0, i_req.imm26, 2'b00};
            K_HALT: n_st = ST_HALT;
            K_ILL:  n_st = ST_ILLEGAL;
            K_MWR: begin
                if ({22'd0, i_req.idx} < 32'(DMEM_WORDS)) begin
                    n_mwr = 1'b1; n_val = i_req.wval;
                end else n_st = ST_FAULT;
            end
            K_MRD: begin
                if ({22'd0, i_req.idx} < 32'(DMEM_WORDS)) is_load = 1'b1;
                else n_st = ST_FAULT;
            end
            K_RRD: begin
                if (i_req.idx < 10'd32)
                    n_val = (i_req.idx[4:0] == 5'd0) ? 32'd0 : r_regs[i_req.idx[4:0]];
                else n_st = ST_FAULT;
            end
            default: n_st = ST_ILLEGAL;
        endcase
        if (i_req.kind == K_MWR || i_req.kind == K_MRD || i_req.kind == K_RRD) begin
            n_pc = r_pc;
        end else if (r_stopped) begin
            n_st = r_stop_code; n_pc = r_pc; n_wr = 1'b0; n_mwr = 1'b0;
            is_load = 1'b0; n_val = 32'd0;
        end else if (n_st != ST_OK) begin
            n_pc = r_pc; n_val = 32'd0;
        end
        if (n_wr && n_dst == 5'd0) n_val = 32'd0;
    end

    // Data memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (take && n_mwr)
            r_dmem[maddr] <= (i_req.kind == K_MWR) ? i_req.wval : rt_v;
        if (take && is_load)
            r_s2_mem <= r_dmem[maddr];
    end

    always_comb begin
        unique case (r_s2_byte)
            2'd0: lbv = {{24{r_s2_mem[7]}},  r_s2_mem[7:0]};
            2'd1: lbv = {{24{r_s2_mem[15]}}, r_s2_mem[15:8]};
            2'd2: lbv = {{24{r_s2_mem[23]}}, r_s2_mem[23:16]};
            default: lbv = {{24{r_s2_mem[31]}}, r_s2_mem[31:24]};
        endcase
    end

    // Architectural state, load stage and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= 32'd0;
            r_data_base <= 32'd8192;
            r_stopped   <= 1'b0;
            r_stop_code <= ST_OK;
            r_s2_valid  <= 1'b0;
            r_ov        <= 1'b0;
            for (int k = 0; k < 32; k++) r_regs[k] <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CODE_BASE) begin
                    r_pc        <= i_cfg_data;
                end else r_data_base <= i_cfg_data;
            end
            // The result register fills from either stage and empties when taken.
            r_ov <= s2_go || (take && !is_load) || (r_ov && !out_free);
            if (s2_go) begin
                r_s2_valid <= 1'b0;
                r_st       <= ST_OK;
                r_pcout    <= r_pc;
                // A memory read op reports the word itself.
                if (r_s2_mrd) begin
                    r_rdata <= r_s2_mem;
                end else if (r_s2_rt == 5'd0) begin
                    r_rdata <= 32'd0;
                end else if (r_s2_lb) begin
                    r_rdata <= lbv;
                end else begin
                    r_rdata <= r_s2_mem;
                end
                if (r_s2_rt != 5'd0) r_regs[r_s2_rt] <= r_s2_lb ? lbv : r_s2_mem;
            end
            if (take) begin
                r_pc <= n_pc;
                if (i_req.kind != K_MWR && i_req.kind != K_MRD && i_req.kind != K_RRD
                    && !r_stopped && n_st != ST_OK) begin
                    r_stopped   <= 1'b1;
                    r_stop_code <= n_st;
                end
                if (n_wr && n_st == ST_OK && n_dst != 5'd0) r_regs[n_dst] <= n_val;
                if (is_load) begin
                    r_s2_valid <= 1'b1;
                    r_s2_lb    <= (i_req.kind == K_LB);
                    r_s2_mrd   <= (i_req.kind == K_MRD);
                    r_s2_byte  <= off[1:0];
                    r_s2_rt    <= (i_req.kind == K_MRD) ? 5'd0 : i_req.rt;
                end else begin
                    r_st    <= n_st;
                    r_pcout <= n_pc;
                    r_rdata <= n_val;
                end
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_status    = r_st;
    assign o_next_pc   = r_pcout;
    assign o_read_data = r_rdata;
endmodule

// ===== rtl/mini_mips_execute_unit.sv =====
// Top level of the execute unit: front decoder, queue and back part.
// Depends on mme_pkg, mme_stream_if, mme_front, mme_queue, mme_back and mini_mips_execute_unit_defines.svh.
//
// Use: requests arrive on s_in (op, instruction, access_index, write_value);
// one result per request leaves on m_out (status, next_pc, read_data) in
// request order. Configuration writes (code_base index 0, data_base index 1)
// must only be made while the unit is idle.
// Path: a request is registered in the queue, then executed into the result
// register; loads and memory reads first pass a registered read of the data
// memory in the load stage.
// Throughput: one request per cycle while m_out takes results; a load
// blocks the next request while its register write completes in the load stage.
// A two-entry queue sits between the decoder and the back part, so the input
// keeps accepting while a result waits. When m_out stalls, the result holds
// and the queue fills, then s_in.ready falls.
// Reset (synchronous, active low) clears the pc to zero, the registers to
// zero and the stopped flag, and restores the data base to 8192; data memory
// keeps its contents and must be written before it is read.
`include "mini_mips_execute_unit_defines.svh"
module mini_mips_execute_unit import mme_pkg::*; #(
    parameter int DMEM_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    mme_stream_if.sink   s_in,
    mme_stream_if.source m_out
);
    t_req req_in, req_q;
    logic q_full, q_valid, q_pop;

    mme_front u_front (
        .i_op(s_in.data.op), .i_instruction(s_in.data.instruction),
        .i_access_index(s_in.data.access_index),
        .i_write_value(s_in.data.write_value), .o_req(req_in)
    );

    assign s_in.ready = !q_full;

    mme_queue u_queue (
        .i_clk, .i_rst_n, .i_push(s_in.valid && !q_full), .i_data(req_in),
        .o_full(q_full), .i_pop(q_pop), .o_valid(q_valid), .o_data(req_q)
    );

    mme_back #(.DMEM_WORDS(DMEM_WORDS)) u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(q_valid), .i_req(req_q), .o_pop(q_pop),
        .o_valid(m_out.valid), .i_ready(m_out.ready),
        .o_status(m_out.data.status), .o_next_pc(m_out.data.next_pc),
        .o_read_data(m_out.data.read_data)
    );

    // Checks on the queue and result stage.
    `MME_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, q_pop |-> q_valid, "pop from empty queue")
    `MME_ASSERT_IMPL(a_hold_out, i_clk, i_rst_n, (m_out.valid && !m_out.ready) |=> m_out.valid, "result dropped")
    `MME_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !q_valid, "queue not empty after reset")
endmodule
